// ----- rtl/bpt_pkg.sv -----
`timescale 1ns / 1ps

package bpt_pkg;

    // Field and register widths
    localparam int ACT_W   = 16;
    localparam int TIME_W  = 31;
    localparam int ERR_W   = 32;
    localparam int STAMP_W = 32;
    localparam int Q14_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int STRK_W  = 4;
    localparam int SINCE_W = 20;
    localparam int RATE_W  = 20;
    localparam int BPM_W   = 20;
    localparam int CFG_W   = 20;
    localparam int CFG_IDX_W = 3;

    localparam logic [SINCE_W-1:0] SINCE_MAX  = '1;
    localparam logic [SINCE_W-1:0] ONSET_GAP  = 20'd4;
    localparam logic [STRK_W-1:0]  STRIKE_MAX = '1;
    localparam logic [BPM_W-1:0]   BPM_MAX    = '1;

    // Register reset values
    localparam logic [15:0] LOCK_TH_RST  = 16'd2458;
    localparam logic [3:0]  UNLOCK_RST   = 4'd3;
    localparam logic [15:0] ONSET_TH_RST = 16'd8192;
    localparam logic [15:0] PER_GAIN_RST = 16'd16384;
    localparam logic [15:0] PH_GAIN_RST  = 16'd16384;
    localparam logic [15:0] BIG_FRAC_RST = 16'd9830;
    localparam logic [15:0] REFR_RST     = 16'd32768;
    localparam logic [19:0] RATE_RST     = 20'd93750;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOCK_TH,
        REG_UNLOCK,
        REG_ONSET_TH,
        REG_PER_GAIN,
        REG_PH_GAIN,
        REG_BIG_FRAC,
        REG_REFR_FRAC,
        REG_RATE
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OBS,
        ST_AGE_DIV,
        ST_AGED,
        ST_ERR,
        ST_MUL,
        ST_UPD,
        ST_FIX_START,
        ST_FIX_DIV,
        ST_FIX_END,
        ST_TRACK,
        ST_TRACK2,
        ST_BPM_DIV,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic obs;
        logic age_start;
        logic aged;
        logic err;
        logic mul;
        logic upd;
        logic fix_start;
        logic fix_end;
        logic track;
        logic track2;
        logic finish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic obs_valid;
        logic obs_go;
        logic aged_exit;
        logic big_jump;
        logic upd_fix;
        logic trk;
        logic div_busy;
        logic out_free;
    } stat_t;

    function automatic logic [TIME_W-1:0] absdiff(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31])
            r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
        logic signed [31:0] r;
        if ((v[34:31] == 4'b0000) || (v[34:31] == 4'b1111))
            r = v[31:0];
        else
            r = v[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return r;
    endfunction

endpackage

// ----- rtl/bpt_if.sv -----
`timescale 1ns / 1ps

interface bpt_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] activation;
    logic        obs_valid;
    logic [30:0] obs_period;
    logic [30:0] obs_phase;
    logic [15:0] obs_strength;
    logic [31:0] obs_stamp;

    modport source (output valid, activation, obs_valid, obs_period, obs_phase,
                    obs_strength, obs_stamp, input ready);
    modport sink (input valid, activation, obs_valid, obs_period, obs_phase,
                  obs_strength, obs_stamp, output ready);
endinterface

interface bpt_out_if;
    logic               valid;
    logic               ready;
    logic               beat;
    logic               locked_flag;
    logic [30:0]        next_beat_in;
    logic [30:0]        beat_period;
    logic [19:0]        tempo_bpm;
    logic signed [31:0] phase_error;
    logic [15:0]        confidence;

    modport source (output valid, beat, locked_flag, next_beat_in, beat_period,
                    tempo_bpm, phase_error, confidence, input ready);
    modport sink (input valid, beat, locked_flag, next_beat_in, beat_period,
                  tempo_bpm, phase_error, confidence, output ready);
endinterface

// ----- rtl/bpt_div.sv -----
`timescale 1ns / 1ps

module bpt_div
    import bpt_pkg::*;
#(
    parameter int DW = 48
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DW-1:0]     dividend,
    input  logic [TIME_W-1:0] divisor,
    output logic              busy,
    output logic [DW-1:0]     quotient,
    output logic [TIME_W-1:0] remainder
);

    localparam int CW = $clog2(DW + 1);

    logic              busy_reg, busy_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [DW-1:0]     num_reg, num_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [TIME_W-1:0] dvs_reg, dvs_next;
    logic [TIME_W:0]   trial;
    logic              take;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial     = {rem_reg, num_reg[DW-1]};
        take      = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            num_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[DW-2:0], take};
            rem_next = take ? TIME_W'(trial - {1'b0, dvs_reg}) : trial[TIME_W-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign quotient  = num_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/bpt_ctrl.sv -----
`timescale 1ns / 1ps

module bpt_ctrl
    import bpt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_OBS;
            ST_OBS:       state_next = (stat.obs_valid && stat.obs_go) ? ST_AGE_DIV : ST_TRACK;
            ST_AGE_DIV:   if (!stat.div_busy) state_next = ST_AGED;
            ST_AGED:      state_next = stat.aged_exit ? ST_TRACK : ST_ERR;
            ST_ERR:       state_next = stat.big_jump ? ST_TRACK : ST_MUL;
            ST_MUL:       state_next = ST_UPD;
            ST_UPD:       state_next = stat.upd_fix ? ST_FIX_START : ST_TRACK;
            ST_FIX_START: state_next = ST_FIX_DIV;
            ST_FIX_DIV:   if (!stat.div_busy) state_next = ST_FIX_END;
            ST_FIX_END:   state_next = ST_TRACK;
            ST_TRACK:     state_next = stat.trk ? ST_TRACK2 : ST_FINISH;
            ST_TRACK2:    state_next = ST_BPM_DIV;
            ST_BPM_DIV:   if (!stat.div_busy) state_next = ST_FINISH;
            ST_FINISH:    if (stat.out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_OBS:
            begin
                cmd.obs       = stat.obs_valid;
                cmd.age_start = stat.obs_valid && stat.obs_go;
            end
            ST_AGED:      cmd.aged = 1'b1;
            ST_ERR:       cmd.err = 1'b1;
            ST_MUL:       cmd.mul = 1'b1;
            ST_UPD:       cmd.upd = 1'b1;
            ST_FIX_START: cmd.fix_start = 1'b1;
            ST_FIX_END:   cmd.fix_end = 1'b1;
            ST_TRACK:     cmd.track = 1'b1;
            ST_TRACK2:    cmd.track2 = 1'b1;
            ST_FINISH:    cmd.finish = stat.out_free;
            default:      cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- rtl/bpt_dp.sv -----
`timescale 1ns / 1ps

module bpt_dp
    import bpt_pkg::*;
#(
    parameter int TIME_FRAC_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic [ACT_W-1:0]      activation,
    input  logic                  obs_valid,
    input  logic [TIME_W-1:0]     obs_period,
    input  logic [TIME_W-1:0]     obs_phase,
    input  logic [Q14_W-1:0]      obs_strength,
    input  logic [STAMP_W-1:0]    obs_stamp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  beat,
    output logic                  locked_flag,
    output logic [TIME_W-1:0]     next_beat_in,
    output logic [TIME_W-1:0]     beat_period,
    output logic [BPM_W-1:0]      tempo_bpm,
    output logic signed [ERR_W-1:0] phase_error,
    output logic [Q14_W-1:0]      confidence
);

    localparam int F  = TIME_FRAC_BITS;
    localparam int DW = STAMP_W + F;
    localparam logic [TIME_W-1:0] ONE_BLOCK = TIME_W'(1) << F;

    // Configuration
    logic [15:0] lock_th_reg, onset_th_reg, per_gain_reg, ph_gain_reg;
    logic [15:0] big_frac_reg, refr_reg;
    logic [3:0]  unlock_reg;
    logic [19:0] rate_reg;

    // Item held for the duration of its work
    logic [ACT_W-1:0]   act_reg;
    logic               ov_reg;
    logic [TIME_W-1:0]  per_reg, ph_reg;
    logic [Q14_W-1:0]   str_reg;
    logic [STAMP_W-1:0] stamp_reg;

    // Tracker state
    logic                     locked_reg, locked_next;
    logic [TIME_W-1:0]        tp_reg, tp_next;
    logic signed [31:0]       btb_reg, btb_next;
    logic signed [31:0]       last_err_reg, last_err_next;
    logic [Q14_W-1:0]         last_str_reg, last_str_next;
    logic [SINCE_W-1:0]       since_reg, since_next;
    logic [STRK_W-1:0]        strike_reg, strike_next;
    logic [ACT_W-1:0]         prev_act_reg, prev_act_next;
    logic [TIME_W-1:0]        prev_per_reg, prev_per_next;
    logic signed [31:0]       pend_reg, pend_next;
    logic [STAMP_W-1:0]       bc_reg, bc_next;
    logic                     fire_reg, fire_next;
    logic                     trk_reg, trk_next;

    // Work registers
    logic                     neg_reg;
    logic [TIME_W-1:0]        aged_reg;
    logic signed [31:0]       err_reg, gp_reg, ge_reg;
    logic [46:0]              lim_reg, prod_reg;
    logic signed [32:0]       dec_reg;

    // Divider
    logic                     div_start, div_busy;
    logic [DW-1:0]            div_dvd, div_quo;
    logic [TIME_W-1:0]        div_dvs, div_rem;

    // Observation aging
    logic [STAMP_W-1:0]       age;
    logic signed [DW:0]       xs, xs_neg;
    logic                     x_neg;
    logic [DW-1:0]            x_mag;
    logic                     str_low, obs_go;
    logic [STRK_W-1:0]        strike_inc;

    // Agreement and jumps
    logic [TIME_W-1:0]        aged, d_prev, d_per_tp, d_prev_tp;
    logic                     agrees, octave, big_jump;

    // Phase error
    logic signed [34:0]       e0, e1, e2, p35;
    logic signed [31:0]       err_sat;

    // Gains
    logic                     dpt_neg, err_neg;
    logic [46:0]              gp_prod;
    logic [31:0]              err_mag;
    logic [47:0]              ge_prod;
    logic [31:0]              ge_mag;
    logic [TIME_W-1:0]        gp_mag;
    logic signed [31:0]       tp_upd32;
    logic                     big_e, confirm, pend_pos, err_pos, upd_fix;
    logic signed [32:0]       ep, ep_mag;
    logic signed [31:0]       nb_conf, nb_gain, nb;

    // Tracking
    logic                     trk_now, onset_fire, wrap;
    logic signed [32:0]       dec;
    logic [63:0]              since_sh;
    logic [22:0]              rate6;

    // Output register
    logic                     out_valid_reg;
    logic                     beat_reg, locked_out_reg;
    logic [TIME_W-1:0]        next_out_reg, period_out_reg;
    logic [BPM_W-1:0]         bpm_out_reg;
    logic signed [31:0]       err_out_reg;
    logic [Q14_W-1:0]         conf_out_reg;
    logic [BPM_W-1:0]         bpm_sat;

    bpt_div #(.DW(DW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Age the observed phase back to this block
    always_comb
    begin
        age        = bc_reg - stamp_reg;
        xs         = $signed({{(DW - TIME_W + 1){1'b0}}, ph_reg})
                   - $signed({1'b0, age, {F{1'b0}}});
        xs_neg     = -xs;
        x_neg      = xs[DW];
        x_mag      = x_neg ? xs_neg[DW-1:0] : xs[DW-1:0];
        str_low    = str_reg < lock_th_reg;
        strike_inc = (strike_reg != STRIKE_MAX) ? strike_reg + STRK_W'(1) : strike_reg;
        obs_go     = !str_low && (per_reg > ONE_BLOCK);
    end

    // Wrap into (0, period] and check agreement
    always_comb
    begin
        if (div_rem == '0)
            aged = per_reg;
        else
            aged = neg_reg ? (per_reg - div_rem) : div_rem;
        d_prev    = absdiff(per_reg, prev_per_reg);
        d_per_tp  = absdiff(per_reg, tp_reg);
        d_prev_tp = absdiff(prev_per_reg, tp_reg);
        agrees    = (prev_per_reg != '0)
                  && (({7'b0, d_prev} * 38'd100) < {7'b0, per_reg});
        octave    = agrees
                  && (({6'b0, d_per_tp} * 37'd50) > {6'b0, tp_reg})
                  && (({6'b0, d_prev_tp} * 37'd50) > {6'b0, tp_reg});
        big_jump  = {d_per_tp, 2'b00} > {2'b00, tp_reg};
    end

    // Phase error folded into half a period
    always_comb
    begin
        p35     = $signed({4'b0, per_reg});
        e0      = $signed({4'b0, aged_reg}) - $signed({{3{btb_reg[31]}}, btb_reg});
        e1      = ((e0 <<< 1) > p35) ? (e0 - p35) : e0;
        e2      = ((e1 <<< 1) < -p35) ? (e1 + p35) : e1;
        err_sat = sat35(e2);
    end

    // Gain products, truncated toward zero
    always_comb
    begin
        dpt_neg  = per_reg < tp_reg;
        gp_prod  = d_per_tp * per_gain_reg;
        gp_mag   = gp_prod[46:16];
        err_neg  = err_reg[31];
        err_mag  = err_neg ? 32'(-err_reg) : 32'(err_reg);
        ge_prod  = err_mag * ph_gain_reg;
        ge_mag   = ge_prod[47:16];
    end

    // Period and phase update
    always_comb
    begin
        tp_upd32 = $signed({1'b0, tp_reg}) + gp_reg;
        big_e    = {err_mag, 16'b0} > {1'b0, lim_reg};
        ep       = $signed({err_reg[31], err_reg}) - $signed({pend_reg[31], pend_reg});
        ep_mag   = ep[32] ? -ep : ep;
        pend_pos = !pend_reg[31] && (pend_reg != '0);
        err_pos  = !err_reg[31] && (err_reg != '0);
        confirm  = (pend_reg != '0) && (pend_pos == err_pos)
                 && ({ep_mag, 16'b0} < {2'b0, lim_reg});
        nb_conf  = sat33($signed({btb_reg[31], btb_reg}) + $signed({err_reg[31], err_reg}));
        nb_gain  = sat33($signed({btb_reg[31], btb_reg}) + $signed({ge_reg[31], ge_reg}));
        nb       = big_e ? nb_conf : nb_gain;
        upd_fix  = (!big_e || confirm) && (nb[31] || (nb == '0));
    end

    // Countdown and beat decision
    always_comb
    begin
        trk_now    = locked_reg && (tp_reg > ONE_BLOCK);
        dec        = $signed({btb_reg[31], btb_reg}) - $signed({2'b0, ONE_BLOCK});
        onset_fire = (act_reg >= onset_th_reg) && (prev_act_reg < onset_th_reg)
                   && (since_reg >= ONSET_GAP);
        wrap       = dec_reg[32] || (dec_reg == '0);
        since_sh   = 64'(since_reg) << (F + 16);
        rate6      = {1'b0, rate_reg, 2'b00} + {2'b0, rate_reg, 1'b0};
        bpm_sat    = (div_quo[DW-1:BPM_W] != '0) ? BPM_MAX : div_quo[BPM_W-1:0];
    end

    // Divider source select
    always_comb
    begin
        div_start = cmd.age_start || cmd.fix_start || cmd.track2;
        div_dvd   = (DW'(rate6)) << F;
        div_dvs   = tp_reg;
        if (cmd.age_start)
        begin
            div_dvd = x_mag;
            div_dvs = per_reg;
        end
        else if (cmd.fix_start)
            div_dvd = DW'($unsigned(-btb_reg));
    end

    // Tracker state next values
    always_comb
    begin
        locked_next   = locked_reg;
        tp_next       = tp_reg;
        btb_next      = btb_reg;
        last_err_next = last_err_reg;
        last_str_next = last_str_reg;
        since_next    = since_reg;
        strike_next   = strike_reg;
        prev_act_next = prev_act_reg;
        prev_per_next = prev_per_reg;
        pend_next     = pend_reg;
        bc_next       = bc_reg;
        fire_next     = fire_reg;
        trk_next      = trk_reg;

        // Advance block count and age since last beat
        if (cmd.load)
        begin
            bc_next   = bc_reg + STAMP_W'(1);
            fire_next = 1'b0;
            trk_next  = 1'b0;
            if (since_reg != SINCE_MAX)
                since_next = since_reg + SINCE_W'(1);
        end

        // Strength check and strikes
        if (cmd.obs)
        begin
            last_str_next = str_reg;
            if (str_low)
            begin
                if (locked_reg)
                begin
                    if (strike_inc >= unlock_reg)
                    begin
                        locked_next = 1'b0;
                        strike_next = '0;
                    end
                    else
                        strike_next = strike_inc;
                end
            end
            else
                strike_next = '0;
        end

        // Lock on agreement, or re-lock on an octave jump
        if (cmd.aged)
        begin
            prev_per_next = per_reg;
            if (!locked_reg)
            begin
                if (agrees)
                begin
                    tp_next       = per_reg;
                    btb_next      = $signed({1'b0, aged});
                    locked_next   = 1'b1;
                    last_err_next = '0;
                end
            end
            else if (octave)
            begin
                tp_next       = per_reg;
                btb_next      = $signed({1'b0, aged});
                last_err_next = '0;
            end
        end

        // Snap on a large period change
        if (cmd.err && big_jump)
        begin
            tp_next       = per_reg;
            btb_next      = $signed({1'b0, aged_reg});
            last_err_next = '0;
        end

        // Filter period, apply or hold the phase error
        if (cmd.upd)
        begin
            tp_next       = tp_upd32[TIME_W-1:0];
            last_err_next = err_reg;
            if (big_e)
            begin
                pend_next = err_reg;
                if (confirm)
                begin
                    btb_next  = nb_conf;
                    pend_next = '0;
                end
            end
            else
            begin
                pend_next = '0;
                btb_next  = nb_gain;
            end
        end

        // Lift a non-positive countdown into (0, period]
        if (cmd.fix_end)
            btb_next = $signed({1'b0, tp_reg - div_rem});

        // Count down, or watch the onset when free running
        if (cmd.track)
        begin
            trk_next  = trk_now;
            fire_next = !trk_now && onset_fire;
        end

        // Fire past the refractory gap and reload the countdown
        if (cmd.track2)
        begin
            if (wrap)
            begin
                fire_next = since_sh >= 64'(prod_reg);
                btb_next  = sat33(dec_reg + $signed({2'b0, tp_reg}));
            end
            else
                btb_next = dec_reg[31:0];
        end

        if (cmd.finish)
        begin
            prev_act_next = act_reg;
            if (fire_reg)
                since_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locked_reg   <= 1'b0;
            tp_reg       <= '0;
            btb_reg      <= '0;
            last_err_reg <= '0;
            last_str_reg <= '0;
            since_reg    <= SINCE_MAX;
            strike_reg   <= '0;
            prev_act_reg <= '0;
            prev_per_reg <= '0;
            pend_reg     <= '0;
            bc_reg       <= '0;
            fire_reg     <= 1'b0;
            trk_reg      <= 1'b0;
        end
        else
        begin
            locked_reg   <= locked_next;
            tp_reg       <= tp_next;
            btb_reg      <= btb_next;
            last_err_reg <= last_err_next;
            last_str_reg <= last_str_next;
            since_reg    <= since_next;
            strike_reg   <= strike_next;
            prev_act_reg <= prev_act_next;
            prev_per_reg <= prev_per_next;
            pend_reg     <= pend_next;
            bc_reg       <= bc_next;
            fire_reg     <= fire_next;
            trk_reg      <= trk_next;
        end
    end

    // Hold the input transfer and the work values
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= activation;
            ov_reg    <= obs_valid;
            per_reg   <= obs_period;
            ph_reg    <= obs_phase;
            str_reg   <= obs_strength;
            stamp_reg <= obs_stamp;
        end
        if (cmd.age_start)
            neg_reg <= x_neg;
        if (cmd.aged)
            aged_reg <= aged;
        if (cmd.err)
            err_reg <= err_sat;
        if (cmd.mul)
        begin
            gp_reg  <= dpt_neg ? -$signed({1'b0, gp_mag}) : $signed({1'b0, gp_mag});
            ge_reg  <= err_neg ? -$signed(ge_mag) : $signed(ge_mag);
            lim_reg <= big_frac_reg * per_reg;
        end
        if (cmd.track)
        begin
            dec_reg  <= dec;
            prod_reg <= refr_reg * tp_reg;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_th_reg  <= LOCK_TH_RST;
            unlock_reg   <= UNLOCK_RST;
            onset_th_reg <= ONSET_TH_RST;
            per_gain_reg <= PER_GAIN_RST;
            ph_gain_reg  <= PH_GAIN_RST;
            big_frac_reg <= BIG_FRAC_RST;
            refr_reg     <= REFR_RST;
            rate_reg     <= RATE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LOCK_TH:   lock_th_reg  <= cfg_data[15:0];
                REG_UNLOCK:    unlock_reg   <= cfg_data[3:0];
                REG_ONSET_TH:  onset_th_reg <= cfg_data[15:0];
                REG_PER_GAIN:  per_gain_reg <= cfg_data[15:0];
                REG_PH_GAIN:   ph_gain_reg  <= cfg_data[15:0];
                REG_BIG_FRAC:  big_frac_reg <= cfg_data[15:0];
                REG_REFR_FRAC: refr_reg     <= cfg_data[15:0];
                REG_RATE:      rate_reg     <= cfg_data[19:0];
                default:       rate_reg     <= rate_reg;
            endcase
        end
    end

    // Output register: drop on transfer, load on commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            beat_reg       <= fire_reg;
            locked_out_reg <= locked_reg;
            next_out_reg   <= (trk_reg && !btb_reg[31] && (btb_reg != '0))
                              ? btb_reg[TIME_W-1:0] : '0;
            period_out_reg <= trk_reg ? tp_reg : '0;
            bpm_out_reg    <= trk_reg ? bpm_sat : '0;
            err_out_reg    <= last_err_reg;
            conf_out_reg   <= last_str_reg;
        end
    end

    always_comb
    begin
        stat.obs_valid = ov_reg;
        stat.obs_go    = obs_go;
        stat.aged_exit = !locked_reg || octave;
        stat.big_jump  = big_jump;
        stat.upd_fix   = upd_fix;
        stat.trk       = trk_now;
        stat.div_busy  = div_busy;
        stat.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign beat         = beat_reg;
    assign locked_flag  = locked_out_reg;
    assign next_beat_in = next_out_reg;
    assign beat_period  = period_out_reg;
    assign tempo_bpm    = bpm_out_reg;
    assign phase_error  = err_out_reg;
    assign confidence   = conf_out_reg;

    // A lock always carries a period above one block
    a_lock_period: assert property (@(posedge clk) disable iff (!rst_n)
        locked_reg |-> (tp_reg > ONE_BLOCK))
        else $error("locked with period at or below one block");

    // Losing lock clears the strike count
    a_unlock_strikes: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(locked_reg) |-> (strike_reg == '0))
        else $error("strike count not cleared on unlock");

    // Between items a locked countdown is positive
    a_countdown_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && locked_reg) |-> (btb_reg > 32'sd0))
        else $error("locked countdown not positive at item start");

endmodule

// ----- rtl/beat_phase_tracker.sv -----
`timescale 1ns / 1ps

// Beat phase tracker: one result per audio block. An item transfers in only
// while the controller is idle. An observation runs an aging modulo and, when
// the phase wraps, a second modulo; a locked countdown runs a tempo division;
// an unlocked block without observation uses no division. All of these share
// one restoring divider, which retires one quotient bit per cycle.
// A finished result sits in the output register while the next item is taken.
// Registers are to be written through cfg_we/cfg_index/cfg_data only while
// idle; the block itself does not enforce it.
module beat_phase_tracker
    import bpt_pkg::*;
#(
    parameter int TIME_FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    bpt_in_if.sink               in_ch,
    bpt_out_if.source            out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    bpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bpt_dp #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .activation   (in_ch.activation),
        .obs_valid    (in_ch.obs_valid),
        .obs_period   (in_ch.obs_period),
        .obs_phase    (in_ch.obs_phase),
        .obs_strength (in_ch.obs_strength),
        .obs_stamp    (in_ch.obs_stamp),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_ready    (out_ch.ready),
        .out_valid    (out_ch.valid),
        .beat         (out_ch.beat),
        .locked_flag  (out_ch.locked_flag),
        .next_beat_in (out_ch.next_beat_in),
        .beat_period  (out_ch.beat_period),
        .tempo_bpm    (out_ch.tempo_bpm),
        .phase_error  (out_ch.phase_error),
        .confidence   (out_ch.confidence)
    );

endmodule
